// ===== hw/rtl/mavm_pkg.sv =====
// ----------------------------------------------------------------------------
// mavm_pkg
// Shared sizes, register indexes and bundle types of the moving average
// voltmeter.
// ----------------------------------------------------------------------------
package mavm_pkg;

  localparam int DEPTH       = 32;
  localparam int SAMPLE_BITS = 12;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(DEPTH);
  localparam int CAL_W     = 16;
  localparam int OFS_W     = 32;
  localparam int AVG_OUT_W = 12;
  localparam int SMP_IN_W  = 12;
  localparam int VOLT_W    = 46;
  localparam int Q_BITS    = 16;
  localparam int PROD_W    = CAL_W + SAMPLE_BITS;
  localparam int DIV_W     = PROD_W + Q_BITS;
  localparam int DVS_W     = CAL_W;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int TOT_W     = DIV_W + 2;
  localparam int SAT_W     = (TOT_W > VOLT_W) ? TOT_W : VOLT_W;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0]       CNT_FULL   = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0]       PTR_LAST   = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0]       SAMPLE_MAX = SUM_W'((1 << SAMPLE_BITS) - 1);
  localparam logic signed [SAT_W-1:0] VOLT_MAX  =
    {{(SAT_W - VOLT_W + 1){1'b0}}, {(VOLT_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] VOLT_MIN  =
    {{(SAT_W - VOLT_W + 1){1'b1}}, {(VOLT_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_MAX  = 3'd0,
    CFG_COUNTS_MIN  = 3'd1,
    CFG_VOLTS_MAX   = 3'd2,
    CFG_VOLTS_MIN   = 3'd3,
    CFG_VOLT_OFFSET = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             cal;
    logic             dc_pos;
    logic             neg;
    logic [CAL_W-1:0] mag;
    logic [CAL_W-1:0] dc;
    logic [OFS_W-1:0] offset;
  } cal_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/moving_average_voltmeter_unit.sv =====
// ----------------------------------------------------------------------------
// moving_average_voltmeter_unit
// Moving average of ADC samples with two-point calibration to signed Q30.16 volts (46 bits).
// ----------------------------------------------------------------------------
// One item at a time: in_stall is high from the edge that takes an item until
// its result enters the output register. A sample while the ring fills runs
// the shared restoring divider for the average, and again for the slope
// scaling when the unit is calibrated with a positive slope; a sample into a
// full ring or a clear runs it only for the slope scaling, and only when
// calibrated with a positive slope. The divider yields one quotient bit per
// cycle; a full ring averages by a shift. A finished item waits in the output
// register while the next one is taken, and a result still stalled there
// holds the next one back. No clearing pass after reset: ring entries are
// read only once they have been written.
// ----------------------------------------------------------------------------
module moving_average_voltmeter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [mavm_pkg::SMP_IN_W-1:0]      sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mavm_pkg::AVG_OUT_W-1:0]     avg_level,
  output logic signed [mavm_pkg::VOLT_W-1:0] volts_q16,
  output logic                              calibrated,
  input  logic                              cfg_write,
  input  logic [mavm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mavm_pkg::CFG_W-1:0]         cfg_data
);
  import mavm_pkg::*;

  logic [CAL_W-1:0]       cal_counts_hi;
  logic [CAL_W-1:0]       cal_counts_lo;
  logic [CAL_W-1:0]       volts_at_max;
  logic [CAL_W-1:0]       volts_at_min;
  logic [OFS_W-1:0]       volt_offset;

  cal_t                   cal;
  logic [CAL_W:0]         dv;
  logic                   ring_wr_en;
  logic [PTR_W-1:0]       ring_addr;
  logic [SAMPLE_BITS-1:0] ring_wr_data;
  logic [SAMPLE_BITS-1:0] ring_rd_data;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_counts_hi <= '0;
      cal_counts_lo <= '0;
      volts_at_max  <= '0;
      volts_at_min  <= '0;
      volt_offset   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COUNTS_MAX:  cal_counts_hi <= cfg_data[CAL_W-1:0];
        CFG_COUNTS_MIN:  cal_counts_lo <= cfg_data[CAL_W-1:0];
        CFG_VOLTS_MAX:   volts_at_max  <= cfg_data[CAL_W-1:0];
        CFG_VOLTS_MIN:   volts_at_min  <= cfg_data[CAL_W-1:0];
        CFG_VOLT_OFFSET: volt_offset   <= cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dv         = {1'b0, volts_at_max} - {1'b0, volts_at_min};
    cal.cal    = (cal_counts_hi != '0) && (cal_counts_lo != '0) &&
                 (volts_at_max != '0) && (volts_at_min != '0);
    cal.dc_pos = (cal_counts_hi > cal_counts_lo);
    cal.neg    = dv[CAL_W];
    cal.mag    = dv[CAL_W] ? volts_at_min - volts_at_max : dv[CAL_W-1:0];
    cal.dc     = cal_counts_hi - cal_counts_lo;
    cal.offset = volt_offset;
  end

  mavm_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_addr),
    .wr_data (ring_wr_data),
    .rd_addr (ring_addr),
    .rd_data (ring_rd_data)
  );

  mavm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mavm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .avg_level    (avg_level),
    .volts_q16    (volts_q16),
    .calibrated   (calibrated),
    .cal          (cal),
    .ring_wr_en   (ring_wr_en),
    .ring_addr    (ring_addr),
    .ring_wr_data (ring_wr_data),
    .ring_rd_data (ring_rd_data),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

endmodule

// ===== hw/rtl/mavm_ring.sv =====
// ----------------------------------------------------------------------------
// mavm_ring
// Sample ring store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mavm_ring (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [mavm_pkg::PTR_W-1:0]       wr_addr,
  input  logic [mavm_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic [mavm_pkg::PTR_W-1:0]       rd_addr,
  output logic [mavm_pkg::SAMPLE_BITS-1:0] rd_data
);
  import mavm_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/mavm_div.sv =====
// ----------------------------------------------------------------------------
// mavm_div
// Shared restoring divider, one quotient bit per cycle, MSB-aligned dividend.
// ----------------------------------------------------------------------------
module mavm_div (
  input  logic                clk,
  input  logic                rst,
  input  mavm_pkg::div_req_t  req,
  output mavm_pkg::div_rsp_t  rsp
);
  import mavm_pkg::*;

  logic              busy;
  logic              done;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  quo;
  logic [STEP_W-1:0] left;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  always_comb begin
    shifted = {rem, dsr[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    ge      = !diff[DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= '0;
        dsr  <= req.dividend;
        dvs  <= req.divisor;
        left <= req.steps;
      end else if (busy) begin
        rem  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo  <= {quo[DIV_W-2:0], ge};
        dsr  <= {dsr[DIV_W-2:0], 1'b0};
        left <= left - STEP_W'(1);
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== hw/rtl/mavm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mavm_ctrl
// Sequencer: ring update, running sum, average and calibrated voltage.
// ----------------------------------------------------------------------------
module mavm_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [mavm_pkg::SMP_IN_W-1:0]      sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mavm_pkg::AVG_OUT_W-1:0]     avg_level,
  output logic signed [mavm_pkg::VOLT_W-1:0] volts_q16,
  output logic                              calibrated,
  input  mavm_pkg::cal_t                    cal,
  output logic                              ring_wr_en,
  output logic [mavm_pkg::PTR_W-1:0]         ring_addr,
  output logic [mavm_pkg::SAMPLE_BITS-1:0]   ring_wr_data,
  input  logic [mavm_pkg::SAMPLE_BITS-1:0]   ring_rd_data,
  output mavm_pkg::div_req_t                div_req,
  input  mavm_pkg::div_rsp_t                div_rsp
);
  import mavm_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    UPDATE,
    AVG_WAIT,
    MUL,
    VOLT,
    VOLT_WAIT,
    OFFSET,
    EMIT
  } state_t;

  state_t                  state;
  logic                    op_r;
  logic [SAMPLE_BITS-1:0]  smp;
  logic [PTR_W-1:0]        ptr;
  logic [CNT_W-1:0]        count;
  logic [SUM_W-1:0]        sum;
  logic [SAMPLE_BITS-1:0]  avg;
  logic [PROD_W-1:0]       prod;
  logic [DIV_W-1:0]        quo;
  logic signed [SAT_W-1:0] total;

  logic                    full;
  logic [SUM_W-1:0]        sum_next;
  logic [CNT_W-1:0]        count_next;
  logic [PTR_W-1:0]        ptr_next;
  logic signed [SAT_W-1:0] signed_quo;
  logic signed [SAT_W-1:0] sat_total;

  always_comb begin
    full       = (count == CNT_FULL);
    sum_next   = full ? sum - SUM_W'(ring_rd_data) + SUM_W'(smp) : sum + SUM_W'(smp);
    count_next = full ? count : count + CNT_W'(1);
    ptr_next   = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
    signed_quo = cal.neg ? -$signed(SAT_W'(quo)) : $signed(SAT_W'(quo));
    if (total > VOLT_MAX) begin
      sat_total = VOLT_MAX;
    end else if (total < VOLT_MIN) begin
      sat_total = VOLT_MIN;
    end else begin
      sat_total = total;
    end
  end

  assign in_stall     = (state != IDLE);
  assign ring_addr    = ptr;
  assign ring_wr_en   = (state == UPDATE) && !op_r;
  assign ring_wr_data = smp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
      ptr           <= '0;
      count         <= '0;
      sum           <= '0;
      avg           <= '0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            smp   <= SAMPLE_BITS'(sample);
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (op_r) begin
            ptr   <= '0;
            count <= '0;
            sum   <= '0;
            avg   <= '0;
            state <= MUL;
          end else begin
            ptr   <= ptr_next;
            count <= count_next;
            sum   <= sum_next;
            if (full) begin
              avg   <= sum_next[SUM_W-1:PTR_W];
              state <= MUL;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= {sum_next, {(DIV_W - SUM_W){1'b0}}};
              div_req.divisor  <= DVS_W'(count_next);
              div_req.steps    <= STEP_W'(SUM_W);
              state            <= AVG_WAIT;
            end
          end
        end
        AVG_WAIT: begin
          if (div_rsp.done) begin
            avg   <= div_rsp.quotient[SAMPLE_BITS-1:0];
            state <= MUL;
          end
        end
        MUL: begin
          prod  <= cal.mag * avg;
          state <= VOLT;
        end
        VOLT: begin
          if (cal.cal && cal.dc_pos) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= {prod, {Q_BITS{1'b0}}};
            div_req.divisor  <= cal.dc;
            div_req.steps    <= STEP_W'(DIV_W);
            state            <= VOLT_WAIT;
          end else begin
            quo   <= '0;
            state <= OFFSET;
          end
        end
        VOLT_WAIT: begin
          if (div_rsp.done) begin
            quo   <= div_rsp.quotient;
            state <= OFFSET;
          end
        end
        OFFSET: begin
          total <= signed_quo + $signed(SAT_W'(cal.offset));
          state <= EMIT;
        end
        EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            avg_level  <= AVG_OUT_W'(avg);
            volts_q16  <= cal.cal ? VOLT_W'(sat_total) : '0;
            calibrated <= cal.cal;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("fill count beyond ring depth");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    sum <= SUM_W'(count) * SAMPLE_MAX)
    else $error("running sum exceeds what the held samples allow");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == AVG_WAIT || state == VOLT_WAIT))
    else $error("divider result arrived with nobody waiting");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while the first is in progress");
`endif

endmodule

// ===== test/mavm_reading_checker.sv =====
// ----------------------------------------------------------------------------
// mavm_reading_checker
// Watches the item, result and register ports of the moving average
// voltmeter, keeps its own copy of the ring, running sum and calibration,
// works out the reading due for every accepted item and compares each
// accepted result, field by field, with the oldest reading still due.
// ----------------------------------------------------------------------------
module mavm_reading_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              op,
  input  logic [mavm_pkg::SMP_IN_W-1:0]      sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [mavm_pkg::AVG_OUT_W-1:0]     avg_level,
  input  logic signed [mavm_pkg::VOLT_W-1:0] volts_q16,
  input  logic                              calibrated,
  input  logic                              cfg_write,
  input  logic [mavm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mavm_pkg::CFG_W-1:0]         cfg_data,
  output int                                failures,
  output int                                outstanding
);
  import mavm_pkg::*;

  localparam longint Q_ONE        = longint'(1) << Q_BITS;
  localparam longint VOLTS_TOP    = (longint'(1) << (VOLT_W - 1)) - 1;
  localparam longint VOLTS_BOTTOM = -(longint'(1) << (VOLT_W - 1));
  localparam int     PRINT_CAP    = 40;

  typedef struct packed {
    logic [AVG_OUT_W-1:0]     avg;
    logic signed [VOLT_W-1:0] volts;
    logic                     cal;
  } reading_t;

  reading_t readings_due[$];
  int       results_seen;

  logic [SAMPLE_BITS-1:0] ring [DEPTH];
  logic [PTR_W-1:0]       oldest_ptr;
  logic [PTR_W-1:0]       newest_ptr;
  logic [CNT_W-1:0]       fill;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] avg_now;

  logic [CAL_W-1:0] counts_hi;
  logic [CAL_W-1:0] counts_lo;
  logic [CAL_W-1:0] volts_hi;
  logic [CAL_W-1:0] volts_lo;
  logic [OFS_W-1:0] offset_q16;

  task automatic report(input string msg);
    if (failures < PRINT_CAP) $display("[%0t] %s", $realtime, msg);
    failures++;
  endtask

  function automatic logic signed [VOLT_W-1:0] volts_for(input logic [SAMPLE_BITS-1:0] level);
    longint hi_v, lo_v, hi_c, lo_c, lvl, span_v, span_c, quot, total;
    hi_v = longint'(volts_hi);
    lo_v = longint'(volts_lo);
    hi_c = longint'(counts_hi);
    lo_c = longint'(counts_lo);
    lvl = longint'(level);
    span_v = hi_v - lo_v;
    span_c = hi_c - lo_c;
    total = longint'(offset_q16);
    if (span_c > 0) begin
      quot = ((span_v < 0 ? -span_v : span_v) * lvl * Q_ONE) / span_c;
      total = (span_v < 0) ? total - quot : total + quot;
    end
    if (total > VOLTS_TOP) total = VOLTS_TOP;
    if (total < VOLTS_BOTTOM) total = VOLTS_BOTTOM;
    return total[VOLT_W-1:0];
  endfunction

  function automatic reading_t predict_reading(input logic clear,
                                               input logic [SMP_IN_W-1:0] raw);
    reading_t r;
    logic [SAMPLE_BITS-1:0] smp;
    smp = raw[SAMPLE_BITS-1:0];
    if (clear) begin
      oldest_ptr = '0;
      newest_ptr = '0;
      fill = '0;
      sum = '0;
      avg_now = '0;
    end else begin
      if (fill < CNT_FULL) begin
        fill = fill + CNT_W'(1);
        sum = sum + SUM_W'(smp);
        avg_now = SAMPLE_BITS'(sum / SUM_W'(fill));
      end else begin
        sum = sum - SUM_W'(ring[oldest_ptr]) + SUM_W'(smp);
        oldest_ptr = (oldest_ptr == PTR_LAST) ? '0 : oldest_ptr + PTR_W'(1);
        avg_now = SAMPLE_BITS'(sum / SUM_W'(DEPTH));
      end
      ring[newest_ptr] = smp;
      newest_ptr = (newest_ptr == PTR_LAST) ? '0 : newest_ptr + PTR_W'(1);
    end
    r.avg = avg_now;
    r.cal = (counts_hi != 0) && (counts_lo != 0) && (volts_hi != 0) && (volts_lo != 0);
    r.volts = r.cal ? volts_for(avg_now) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t due;
    if (rst) begin
      readings_due.delete();
      failures = 0;
      results_seen = 0;
      oldest_ptr = '0;
      newest_ptr = '0;
      fill = '0;
      sum = '0;
      avg_now = '0;
      counts_hi = '0;
      counts_lo = '0;
      volts_hi = '0;
      volts_lo = '0;
      offset_q16 = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_COUNTS_MAX:  counts_hi = cfg_data[CAL_W-1:0];
          CFG_COUNTS_MIN:  counts_lo = cfg_data[CAL_W-1:0];
          CFG_VOLTS_MAX:   volts_hi = cfg_data[CAL_W-1:0];
          CFG_VOLTS_MIN:   volts_lo = cfg_data[CAL_W-1:0];
          CFG_VOLT_OFFSET: offset_q16 = cfg_data[OFS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report($sformatf("result %0d arrived with nothing due", results_seen));
        end else begin
          due = readings_due.pop_front();
          if (avg_level !== due.avg)
            report($sformatf("result %0d avg_level got %0d want %0d",
                             results_seen, avg_level, due.avg));
          if (volts_q16 !== due.volts)
            report($sformatf("result %0d volts_q16 got %0d want %0d",
                             results_seen, volts_q16, due.volts));
          if (calibrated !== due.cal)
            report($sformatf("result %0d calibrated got %0b want %0b",
                             results_seen, calibrated, due.cal));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) readings_due.push_back(predict_reading(op, sample));
    end
    outstanding <= readings_due.size();
  end

endmodule

// ===== test/tb_moving_average_voltmeter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_voltmeter_unit
// Drives samples and clears into the moving average voltmeter under a series
// of calibration settings, with bursty input and a varying output stall, and
// leaves prediction and comparison to the reading checker.
// ----------------------------------------------------------------------------
module tb_moving_average_voltmeter_unit;
  import mavm_pkg::*;

  localparam int ITEM_TARGET   = 1200;
  localparam int PHASE_ITEMS   = 100;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [SMP_IN_W-1:0] SAMPLE_TOP = '1;
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     op = OP_SAMPLE;
  logic [SMP_IN_W-1:0]      sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [AVG_OUT_W-1:0]     avg_level;
  logic signed [VOLT_W-1:0] volts_q16;
  logic                     calibrated;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_COUNTS_MAX;
  logic [CFG_W-1:0]         cfg_data = '0;

  int failures;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int clears_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_run = 0;
  int stall_clock = 0;

  moving_average_voltmeter_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .avg_level  (avg_level),
    .volts_q16  (volts_q16),
    .calibrated (calibrated),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mavm_reading_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .avg_level   (avg_level),
    .volts_q16   (volts_q16),
    .calibrated  (calibrated),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Receiver: free-running, then short random stalls, then long stalls.
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ((stall_clock / 2500) % 3)
        0: begin
          out_stall <= 1'b0;
          stall_run <= 20;
        end
        1: begin
          out_stall <= ($urandom_range(0, 1) == 1);
          stall_run <= $urandom_range(0, 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) == 0);
          stall_run <= $urandom_range(0, 40);
        end
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [SMP_IN_W-1:0] value);
    in_valid <= 1'b1;
    op <= kind;
    sample <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (kind == OP_CLEAR) clears_sent++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        in_valid <= 1'b0;
        op <= 1'($urandom_range(0, 1));
        sample <= SMP_IN_W'($urandom);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 100)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CAL_W-1:0] c_hi, input logic [CAL_W-1:0] c_lo,
                           input logic [CAL_W-1:0] v_hi, input logic [CAL_W-1:0] v_lo,
                           input logic [OFS_W-1:0] ofs);
    wait_idle();
    write_reg(CFG_COUNTS_MAX, CFG_W'(c_hi));
    write_reg(CFG_COUNTS_MIN, CFG_W'(c_lo));
    write_reg(CFG_VOLTS_MAX, CFG_W'(v_hi));
    write_reg(CFG_VOLTS_MIN, CFG_W'(v_lo));
    write_reg(CFG_VOLT_OFFSET, CFG_W'(ofs));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic random_configure();
    logic [CAL_W-1:0] c_hi, c_lo, v_hi, v_lo;
    logic [OFS_W-1:0] ofs;
    c_hi = CAL_W'($urandom);
    c_lo = CAL_W'($urandom);
    v_hi = CAL_W'($urandom);
    v_lo = CAL_W'($urandom);
    ofs = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        c_lo = CAL_W'($urandom_range(1, 2000));
        c_hi = c_lo + CAL_W'($urandom_range(1, 4000));
        v_lo = CAL_W'($urandom_range(1, 1000));
        v_hi = CAL_W'($urandom_range(1, 65535));
        if ($urandom_range(0, 1) == 0) ofs = $urandom_range(0, 1 << 20);
      end
      5, 6: ;
      7: begin
        case ($urandom_range(0, 3))
          0: c_hi = '0;
          1: c_lo = '0;
          2: v_hi = '0;
          default: v_lo = '0;
        endcase
      end
      8: begin
        c_hi = CAL_W'($urandom_range(1, 65535));
        c_lo = CAL_W'($urandom_range(c_hi, 65535));
      end
      default: begin
        c_hi = '0;
        c_lo = '0;
        v_hi = '0;
        v_lo = '0;
      end
    endcase
    configure(c_hi, c_lo, v_hi, v_lo, ofs);
  endtask

  function automatic logic [SMP_IN_W-1:0] pick_sample(input int level);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = int'(SAMPLE_TOP);
      2, 3: v = $urandom_range(0, SAMPLE_TOP);
      default: v = level + $urandom_range(0, 64) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_TOP)) v = int'(SAMPLE_TOP);
    return v[SMP_IN_W-1:0];
  endfunction

  initial begin
    int phase;
    int level;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // uncalibrated after reset
    send_item(OP_SAMPLE, SAMPLE_TOP);
    send_item(OP_SAMPLE, '0);
    send_item(OP_CLEAR, SAMPLE_TOP);
    send_item(OP_SAMPLE, SAMPLE_TOP);
    // widest positive slope, largest offset
    configure(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, SAMPLE_TOP);
    send_item(OP_SAMPLE, SAMPLE_TOP);
    send_item(OP_CLEAR, '0);
    send_item(OP_SAMPLE, '0);
    // upper count point below the lower one
    configure(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 32'h1234_5678);
    send_item(OP_SAMPLE, SAMPLE_TOP);
    send_item(OP_CLEAR, SAMPLE_TOP);
    // steepest negative slope
    configure(16'h0002, 16'h0001, 16'h0001, 16'hFFFF, '0);
    send_item(OP_SAMPLE, SAMPLE_TOP);
    send_item(OP_SAMPLE, SAMPLE_TOP);
    // equal count points
    configure(16'd100, 16'd100, 16'd10, 16'd5, 32'h8000_0000);
    send_item(OP_SAMPLE, 12'h800);
    // one calibration point zero
    configure(16'd500, 16'd0, 16'd300, 16'd100, 32'd7);
    send_item(OP_SAMPLE, 12'h3E8);

    for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
      random_configure();
      gaps_on = (phase % 4 != 1);
      level = $urandom_range(0, SAMPLE_TOP);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 59) == 0) send_item(OP_CLEAR, SMP_IN_W'($urandom));
        else send_item(OP_SAMPLE, pick_sample(level));
        if ($urandom_range(0, 149) == 0) wait_idle();
        if ($urandom_range(0, 49) == 0) level = $urandom_range(0, SAMPLE_TOP);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d clears) across %0d calibration settings in %0d cycles",
             items_sent, clears_sent, settings_used, cycle_count);
    $display("Mismatches: %0d, readings still due: %0d", failures, outstanding);
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
